/* rtl/trf_pkg.sv */
`default_nettype none

package trf_pkg;

    localparam int NCH            = 3;
    localparam int LVL_W          = 8;
    localparam int DUTY_W         = 11;
    localparam int PWM_FULL_SCALE = 1024;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 32;
    localparam int IN_TIME_W      = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_RED   = 3'd0,
        REG_START_GREEN = 3'd1,
        REG_START_BLUE  = 3'd2,
        REG_END_RED     = 3'd3,
        REG_END_GREEN   = 3'd4,
        REG_END_BLUE    = 3'd5,
        REG_FADE_START  = 3'd6,
        REG_FADE_LENGTH = 3'd7
    } cfg_reg_t;

    // per-channel payload walking down the cell row
    typedef struct packed {
        logic [LVL_W-1:0] s;    // start level
        logic [LVL_W-1:0] t;    // end level
        logic [LVL_W-1:0] a;    // |t - s|
        logic             dn;   // fading down (t < s)
        logic [LVL_W-1:0] q;    // partial quotient
    } chan_t;

    typedef struct packed {
        logic valid;
        logic zero_len;  // window of length zero
        logic full;      // elapsed equals length
    } ctl_t;

endpackage

`default_nettype wire

/* rtl/timed_rgb_fade.sv */
// Pipeline: a request in the fade window passes through one setup stage, eight
// quotient-bit cells and one output register before its result shows.
// Throughput: one request per cycle; the whole cell row advances together and
// holds only while a result waits on m_axis_tready. Requests outside the window vanish.
// Reset: synchronous, active low on aresetn; clears all valid bits and all
// configuration registers to zero.
`default_nettype none

module timed_rgb_fade #(
    parameter int TIME_BITS = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // request: now_time [31:0]
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,
    // result: duty_red [10:0], duty_green [21:11], duty_blue [32:22], zero fill [39:33]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,
    // configuration write port
    input  wire logic        cfg_we,
    input  wire logic [trf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [trf_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    // Time width actually held by the window registers; the time port carries 32 bits.
    localparam int TW     = (TIME_BITS < trf_pkg::IN_TIME_W) ? TIME_BITS : trf_pkg::IN_TIME_W;
    localparam int NCELLS = trf_pkg::LVL_W;
    localparam int NCH    = trf_pkg::NCH;
    localparam int DW     = trf_pkg::DUTY_W;

    // Configuration registers
    logic [NCH-1:0][trf_pkg::LVL_W-1:0] start_lvl_reg;
    logic [NCH-1:0][trf_pkg::LVL_W-1:0] end_lvl_reg;
    logic [TW-1:0]                      fade_start_reg;
    logic [TW-1:0]                      fade_length_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_lvl_reg   <= '0;
            end_lvl_reg     <= '0;
            fade_start_reg  <= '0;
            fade_length_reg <= '0;
        end else if (cfg_we) begin
            case (trf_pkg::cfg_reg_t'(cfg_index))
                trf_pkg::REG_START_RED:   start_lvl_reg[0] <= cfg_wdata[7:0];
                trf_pkg::REG_START_GREEN: start_lvl_reg[1] <= cfg_wdata[7:0];
                trf_pkg::REG_START_BLUE:  start_lvl_reg[2] <= cfg_wdata[7:0];
                trf_pkg::REG_END_RED:     end_lvl_reg[0]   <= cfg_wdata[7:0];
                trf_pkg::REG_END_GREEN:   end_lvl_reg[1]   <= cfg_wdata[7:0];
                trf_pkg::REG_END_BLUE:    end_lvl_reg[2]   <= cfg_wdata[7:0];
                trf_pkg::REG_FADE_START:  fade_start_reg   <= cfg_wdata[TW-1:0];
                trf_pkg::REG_FADE_LENGTH: fade_length_reg  <= cfg_wdata[TW-1:0];
                default: begin
                end
            endcase
        end
    end

    // Advance the whole row whenever the output register is free or being drained.
    logic adv;
    assign adv           = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    // Links between stages: index 0 is the setup stage output, index k+1 the output of cell k.
    trf_pkg::ctl_t                ctl_w  [0:NCELLS];
    trf_pkg::chan_t [NCH-1:0]     chan_w [0:NCELLS];
    logic [NCH-1:0][TW-1:0]       r_w    [0:NCELLS];
    logic [TW-1:0]                e_w    [0:NCELLS];
    logic [TW-1:0]                d_w    [0:NCELLS];
    logic [TW-1:0]                de_w   [0:NCELLS];

    // Window check, elapsed time and per-channel magnitude/direction.
    trf_front #(.TW(TW)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .req_valid (s_axis_tvalid),
        .now       (s_axis_tdata[TW-1:0]),
        .win_start (fade_start_reg),
        .win_len   (fade_length_reg),
        .lvl_start (start_lvl_reg),
        .lvl_end   (end_lvl_reg),
        .ctl_out   (ctl_w[0]),
        .chan_out  (chan_w[0]),
        .e_out     (e_w[0]),
        .d_out     (d_w[0]),
        .de_out    (de_w[0])
    );

    // Remainder starts at zero for every channel.
    assign r_w[0] = '0;

    // Row of quotient cells, most significant bit of the magnitude first.
    for (genvar k = 0; k < NCELLS; k++) begin : g_cell
        trf_cell #(.TW(TW), .BIT(NCELLS - 1 - k)) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .adv      (adv),
            .ctl_in   (ctl_w[k]),
            .chan_in  (chan_w[k]),
            .r_in     (r_w[k]),
            .e_in     (e_w[k]),
            .d_in     (d_w[k]),
            .de_in    (de_w[k]),
            .ctl_out  (ctl_w[k+1]),
            .chan_out (chan_w[k+1]),
            .r_out    (r_w[k+1]),
            .e_out    (e_w[k+1]),
            .d_out    (d_w[k+1]),
            .de_out   (de_w[k+1])
        );
    end

    // Level, inverted duty and output register.
    logic [NCH-1:0][DW-1:0] duty;

    trf_back #(.TW(TW)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .ctl_in    (ctl_w[NCELLS]),
        .chan_in   (chan_w[NCELLS]),
        .r_in      (r_w[NCELLS]),
        .res_valid (m_axis_tvalid),
        .duty      (duty)
    );

    assign m_axis_tdata = {7'd0, duty[2], duty[1], duty[0]};

endmodule

`default_nettype wire

/* rtl/trf_front.sv */
`default_nettype none

module trf_front #(
    parameter int TW = 32
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   adv,
    input  wire logic                                   req_valid,
    input  wire logic [TW-1:0]                          now,
    input  wire logic [TW-1:0]                          win_start,
    input  wire logic [TW-1:0]                          win_len,
    input  wire logic [trf_pkg::NCH-1:0][trf_pkg::LVL_W-1:0] lvl_start,
    input  wire logic [trf_pkg::NCH-1:0][trf_pkg::LVL_W-1:0] lvl_end,
    output trf_pkg::ctl_t                               ctl_out,
    output trf_pkg::chan_t [trf_pkg::NCH-1:0]           chan_out,
    output logic [TW-1:0]                               e_out,
    output logic [TW-1:0]                               d_out,
    output logic [TW-1:0]                               de_out
);

    trf_pkg::ctl_t                     ctl_reg, ctl_next;
    trf_pkg::chan_t [trf_pkg::NCH-1:0] chan_reg, chan_next;
    logic [TW-1:0] e_reg, d_reg, de_reg;
    logic [TW-1:0] elapsed;
    logic          in_win;

    always_comb begin
        elapsed = now - win_start;
        in_win  = (now >= win_start) && (elapsed <= win_len);
        ctl_next.valid    = req_valid && in_win;
        ctl_next.zero_len = (win_len == '0);
        ctl_next.full     = (elapsed == win_len);
        for (int c = 0; c < trf_pkg::NCH; c++) begin
            chan_next[c].s  = lvl_start[c];
            chan_next[c].t  = lvl_end[c];
            chan_next[c].dn = lvl_end[c] < lvl_start[c];
            chan_next[c].a  = chan_next[c].dn ? (lvl_start[c] - lvl_end[c])
                                              : (lvl_end[c] - lvl_start[c]);
            chan_next[c].q  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (adv) begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            chan_reg <= chan_next;
            e_reg    <= elapsed;
            d_reg    <= win_len;
            de_reg   <= win_len - elapsed;
        end
    end

    assign ctl_out  = ctl_reg;
    assign chan_out = chan_reg;
    assign e_out    = e_reg;
    assign d_out    = d_reg;
    assign de_out   = de_reg;

endmodule

`default_nettype wire

/* rtl/trf_cell.sv */
`default_nettype none

// One quotient bit of floor(a*e/d) for every channel.
module trf_cell #(
    parameter int TW  = 32,
    parameter int BIT = 7
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  adv,
    input  wire trf_pkg::ctl_t                         ctl_in,
    input  wire trf_pkg::chan_t [trf_pkg::NCH-1:0]     chan_in,
    input  wire logic [trf_pkg::NCH-1:0][TW-1:0]       r_in,
    input  wire logic [TW-1:0]                         e_in,
    input  wire logic [TW-1:0]                         d_in,
    input  wire logic [TW-1:0]                         de_in,
    output trf_pkg::ctl_t                              ctl_out,
    output trf_pkg::chan_t [trf_pkg::NCH-1:0]          chan_out,
    output logic [trf_pkg::NCH-1:0][TW-1:0]            r_out,
    output logic [TW-1:0]                              e_out,
    output logic [TW-1:0]                              d_out,
    output logic [TW-1:0]                              de_out
);

    trf_pkg::ctl_t                     ctl_reg;
    trf_pkg::chan_t [trf_pkg::NCH-1:0] chan_reg, chan_next;
    logic [trf_pkg::NCH-1:0][TW-1:0]   r_reg, r_next;
    logic [TW-1:0] e_reg, d_reg, de_reg;

    always_comb begin
        logic [TW:0]  r2x;
        logic         dbl_ge;
        logic [TW-1:0] r1;
        logic         inc;
        chan_next = chan_in;
        r_next    = r_in;
        for (int c = 0; c < trf_pkg::NCH; c++) begin
            // double the remainder, reduce once
            r2x    = {r_in[c], 1'b0};
            dbl_ge = r2x >= {1'b0, d_in};
            r1     = dbl_ge ? TW'(r2x - {1'b0, d_in}) : r2x[TW-1:0];
            inc    = 1'b0;
            r_next[c] = r1;
            // add e when this bit of a is set
            if (chan_in[c].a[BIT]) begin
                if (ctl_in.full) begin
                    inc = 1'b1;
                end else if (r1 >= de_in) begin
                    inc       = 1'b1;
                    r_next[c] = r1 - de_in;
                end else begin
                    r_next[c] = r1 + e_in;
                end
            end
            chan_next[c].q = {chan_in[c].q[trf_pkg::LVL_W-2:0], 1'b0}
                             + trf_pkg::LVL_W'(dbl_ge) + trf_pkg::LVL_W'(inc);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (adv) begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            chan_reg <= chan_next;
            r_reg    <= r_next;
            e_reg    <= e_in;
            d_reg    <= d_in;
            de_reg   <= de_in;
        end
    end

    assign ctl_out  = ctl_reg;
    assign chan_out = chan_reg;
    assign r_out    = r_reg;
    assign e_out    = e_reg;
    assign d_out    = d_reg;
    assign de_out   = de_reg;

endmodule

`default_nettype wire

/* rtl/trf_back.sv */
`default_nettype none

module trf_back #(
    parameter int TW = 32
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                adv,
    input  wire trf_pkg::ctl_t                       ctl_in,
    input  wire trf_pkg::chan_t [trf_pkg::NCH-1:0]   chan_in,
    input  wire logic [trf_pkg::NCH-1:0][TW-1:0]     r_in,
    output logic                                     res_valid,
    output logic [trf_pkg::NCH-1:0][trf_pkg::DUTY_W-1:0] duty
);

    logic                                          valid_reg;
    logic [trf_pkg::NCH-1:0][trf_pkg::DUTY_W-1:0]  duty_reg, duty_next;

    always_comb begin
        logic [trf_pkg::LVL_W-1:0] level;
        logic [31:0]               diff;
        for (int c = 0; c < trf_pkg::NCH; c++) begin
            if (ctl_in.zero_len) begin
                level = chan_in[c].t;
            end else if (chan_in[c].dn) begin
                level = chan_in[c].s - chan_in[c].q
                        - trf_pkg::LVL_W'(r_in[c] != '0);
            end else begin
                level = chan_in[c].s + chan_in[c].q;
            end
            diff = 32'(trf_pkg::PWM_FULL_SCALE) - {24'd0, level};
            duty_next[c] = diff[trf_pkg::DUTY_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= ctl_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            duty_reg <= duty_next;
        end
    end

    assign res_valid = valid_reg;
    assign duty      = duty_reg;

endmodule

`default_nettype wire
